@@ src/assert_macros.svh @@
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a plain property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bds2x2_pkg.sv @@
package bds2x2_pkg;

    localparam int MAX_WIDTH_DEF    = 4096;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int FIELD_BITS       = 16;
    localparam int CFG_BITS         = 13;
    localparam int HEIGHT_LIMIT     = 4096;
    localparam int ROW_BITS         = 12;
    // Room for two pair sums plus rounding at the widest channel.
    localparam int SUM_BITS         = FIELD_BITS + 3;

    localparam logic REG_SOURCE_WIDTH  = 1'b0;
    localparam logic REG_SOURCE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [FIELD_BITS-1:0] red_in;
        logic [FIELD_BITS-1:0] green_in;
        logic [FIELD_BITS-1:0] blue_in;
        logic [FIELD_BITS-1:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] red_out;
        logic [FIELD_BITS-1:0] green_out;
        logic [FIELD_BITS-1:0] blue_out;
        logic [FIELD_BITS-1:0] alpha_out;
        logic                  frame_end;
    } pixel_out_t;

endpackage

@@ src/bds2x2_ram.sv @@
module bds2x2_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/box_downsample_2x2.sv @@
// An output pixel comes from the transfer of the source pixel that completes its 2x2
// block, through stage 1 (line buffer read), then the output register (round and register).
// Throughput: one source pixel per cycle while the sink keeps up; one line buffer port pair
// (one write, one read per cycle) sets that rate.
// Reset clears counters, size registers (width and height become 1) and valid
// flags at once; the line buffer is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module box_downsample_2x2
    import bds2x2_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                src_valid,
    output logic                src_ready,
    input  pixel_in_t           src_pixel,

    output logic                dst_valid,
    input  logic                dst_ready,
    output pixel_out_t          dst_pixel,

    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    // Pair sums carry one extra bit; the line buffer holds all four channels.
    localparam int PW    = CHANNEL_BITS + 1;
    localparam int LD    = MAX_WIDTH / 2;
    localparam int AW    = (LD > 1) ? $clog2(LD) : 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SZW_A = $clog2(MAX_WIDTH + 1);
    localparam int SZ_W  = (SZW_A > CFG_BITS) ? SZW_A : CFG_BITS;

    // ------------------------------------------------------------------
    // Size registers. Clamp and precompute the compare values on a write
    // so the per-pixel path only does equality checks.
    // ------------------------------------------------------------------
    logic [CW-1:0]       w_last_reg;      // width - 1
    logic                w_odd_reg;
    logic                w_one_reg;
    logic [CW-1:0]       ow_last_reg;     // output width - 1
    logic [ROW_BITS-1:0] h_last_reg;      // height - 1
    logic                h_odd_reg;
    logic                h_one_reg;
    logic [ROW_BITS-1:0] oh_row_last_reg; // last source row of the last block row

    logic [SZ_W-1:0]     w_size;
    logic [SZ_W-1:0]     w_clamped;
    logic [CFG_BITS-1:0] h_clamped;
    logic [CFG_BITS-1:0] h_even;

    assign w_size = SZ_W'(cfg_data);

    always_comb
    begin
        if (w_size == '0)
        begin
            w_clamped = SZ_W'(1);
        end
        else if (w_size > SZ_W'(MAX_WIDTH))
        begin
            w_clamped = SZ_W'(MAX_WIDTH);
        end
        else
        begin
            w_clamped = w_size;
        end

        if (cfg_data == '0)
        begin
            h_clamped = CFG_BITS'(1);
        end
        else if (cfg_data > CFG_BITS'(HEIGHT_LIMIT))
        begin
            h_clamped = CFG_BITS'(HEIGHT_LIMIT);
        end
        else
        begin
            h_clamped = cfg_data;
        end

        h_even = {h_clamped[CFG_BITS-1:1], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg      <= '0;
            w_odd_reg       <= 1'b1;
            w_one_reg       <= 1'b1;
            ow_last_reg     <= '0;
            h_last_reg      <= '0;
            h_odd_reg       <= 1'b1;
            h_one_reg       <= 1'b1;
            oh_row_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:
                begin
                    w_last_reg  <= CW'(w_clamped - SZ_W'(1));
                    w_odd_reg   <= w_clamped[0];
                    w_one_reg   <= (w_clamped == SZ_W'(1));
                    ow_last_reg <= (w_clamped == SZ_W'(1)) ? '0 :
                                   CW'((w_clamped >> 1) - SZ_W'(1));
                end
                REG_SOURCE_HEIGHT:
                begin
                    h_last_reg      <= ROW_BITS'(h_clamped - CFG_BITS'(1));
                    h_odd_reg       <= h_clamped[0];
                    h_one_reg       <= (h_clamped == CFG_BITS'(1));
                    oh_row_last_reg <= (h_clamped == CFG_BITS'(1)) ? '0 :
                                       ROW_BITS'(h_even - CFG_BITS'(1));
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. Stage 1 waits on the line buffer read; the output register
    // parts it from the sink. Take a new pixel whenever stage 1 is empty or moves on.
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    logic                  s1_line_reg;   // add the stored line pair
    logic                  s1_end_reg;
    logic [3:0][PW-1:0]    s1_pair_reg;
    logic                  out_valid_reg;
    pixel_out_t            out_reg;
    logic                  s1_adv;
    logic                  src_fire;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || dst_ready);
    assign src_ready = !s1_valid_reg || s1_adv;
    assign src_fire  = src_valid && src_ready;
    assign dst_valid = out_valid_reg;
    assign dst_pixel = out_reg;

    // ------------------------------------------------------------------
    // Position in the source frame.
    // ------------------------------------------------------------------
    logic [CW-1:0]       col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic                col_last;
    logic                row_last;
    logic                col_in_range;
    logic                row_in_range;
    logic [CW-1:0]       x_full;

    assign col_last     = (col_reg == w_last_reg);
    assign row_last     = (row_reg == h_last_reg);
    // Drop the odd last column or row.
    assign col_in_range = !(col_last && w_odd_reg);
    assign row_in_range = !(row_last && h_odd_reg);
    assign x_full       = w_one_reg ? '0 : (col_reg >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we)
        begin
            // Restart the frame on any size write.
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (src_fire)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Horizontal pairing. Hold the even-column pixel, add the odd one.
    // A one-pixel-wide source pairs each pixel with itself.
    // ------------------------------------------------------------------
    logic [3:0][CHANNEL_BITS-1:0] px;
    logic [3:0][CHANNEL_BITS-1:0] held_reg;
    logic [3:0][PW-1:0]           pair;
    logic                         have_pair;
    logic                         hold_even;

    assign px[0] = src_pixel.red_in[CHANNEL_BITS-1:0];
    assign px[1] = src_pixel.green_in[CHANNEL_BITS-1:0];
    assign px[2] = src_pixel.blue_in[CHANNEL_BITS-1:0];
    assign px[3] = src_pixel.alpha_in[CHANNEL_BITS-1:0];

    assign hold_even = !w_one_reg && col_in_range && !col_reg[0];
    assign have_pair = w_one_reg || (col_in_range && col_reg[0]);

    always_comb
    begin
        for (int ch = 0; ch < 4; ch++)
        begin
            if (w_one_reg)
            begin
                pair[ch] = {px[ch], 1'b0};
            end
            else
            begin
                pair[ch] = PW'(held_reg[ch]) + PW'(px[ch]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (src_fire && hold_even)
        begin
            held_reg <= px;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer. Even source rows write pair sums, odd source rows read them
    // back. A write always lands at least one transfer before the matching
    // read, so the registered read sees it without forwarding.
    // ------------------------------------------------------------------
    logic               ram_we;
    logic               ram_re;
    logic               emit;
    logic               end_flag;
    logic [AW-1:0]      ram_addr;
    logic [4*PW-1:0]    ram_rdata;
    logic [3:0][PW-1:0] line_pair;

    assign ram_addr = x_full[AW-1:0];
    assign ram_we   = src_fire && have_pair && !h_one_reg && row_in_range && !row_reg[0];
    assign emit     = src_fire && have_pair &&
                      (h_one_reg || (row_in_range && row_reg[0]));
    assign ram_re   = emit && !h_one_reg;
    assign end_flag = (x_full == ow_last_reg) &&
                      (h_one_reg || (row_reg == oh_row_last_reg));

    bds2x2_ram #(
        .WIDTH (4 * PW),
        .DEPTH (LD)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (pair),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    assign line_pair = ram_rdata;

    // Stage 1: hold the pair sum while the line buffer read completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (src_ready)
        begin
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_pair_reg <= pair;
            s1_line_reg <= !h_one_reg;
            s1_end_reg  <= end_flag;
        end
    end

    // ------------------------------------------------------------------
    // Vertical add, round half up, divide by four.
    // ------------------------------------------------------------------
    logic [3:0][SUM_BITS-1:0]   sum;
    logic [3:0][FIELD_BITS-1:0] avg;
    pixel_out_t                 out_next;

    always_comb
    begin
        for (int ch = 0; ch < 4; ch++)
        begin
            if (s1_line_reg)
            begin
                sum[ch] = SUM_BITS'(line_pair[ch]) + SUM_BITS'(s1_pair_reg[ch])
                          + SUM_BITS'(2);
            end
            else
            begin
                sum[ch] = SUM_BITS'({s1_pair_reg[ch], 1'b0}) + SUM_BITS'(2);
            end
            avg[ch] = sum[ch][FIELD_BITS+1:2];
        end
        out_next.red_out   = avg[0];
        out_next.green_out = avg[1];
        out_next.blue_out  = avg[2];
        out_next.alpha_out = avg[3];
        out_next.frame_end = s1_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dst_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_reg <= out_next;
        end
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_no_rw_same_cycle, !(ram_we && ram_re), "line buffer read and write overlap")
    `ASSERT_IMPLY(a_stall_no_read, s1_valid_reg && !s1_adv, !ram_re, "read while stage 1 stalled")
    `ASSERT_ALWAYS(a_col_in_frame, col_reg <= w_last_reg, "column counter beyond width")
    `ASSERT_NEXT(a_stall_holds, s1_valid_reg && !s1_adv, s1_valid_reg, "stage 1 lost its item")

endmodule

@@ test/tb_box_downsample_2x2.sv @@
`timescale 1ns / 1ps

module tb_box_downsample_2x2;
    import bds2x2_pkg::*;

    // Cycles without any transfer before the run is declared hung. The longest
    // correct quiet stretch is a source gap plus an output stall plus the
    // settle before a register write.
    localparam int unsigned STALL_LIMIT = 1000;
    // Cycles to let in-flight pixels (dropped ones included) drain before a
    // register write; the last transfer passes stage 1 and the output register.
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned RANDOM_PIXELS = 480;
    localparam int unsigned LINE_DEPTH = MAX_WIDTH_DEF / 2;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    // One row of the directed stimulus table.
    typedef struct {
        row_kind_t            kind;
        logic                 reg_index;
        logic [CFG_BITS-1:0]  reg_value;
        pixel_in_t            px;
        bit                   pinned;
        pixel_out_t           want;
    } step_t;

    // Per accepted pixel: either a hand-typed block average or none.
    typedef struct {
        bit         pinned;
        pixel_out_t want;
    } typed_outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                src_valid = 1'b0;
    logic                src_ready;
    pixel_in_t           src_pixel = '0;
    logic                dst_valid;
    logic                dst_ready = 1'b0;
    pixel_out_t          dst_pixel;
    logic                cfg_we = 1'b0;
    logic                cfg_index = REG_SOURCE_WIDTH;
    logic [CFG_BITS-1:0] cfg_data = '0;

    // Predictor state: size registers, scan position, held even pixel and
    // the line of horizontal pair sums from the last even source row.
    logic [CFG_BITS-1:0] width_reg = 13'd1;
    logic [CFG_BITS-1:0] height_reg = 13'd1;
    int unsigned         col_pos = 0;
    int unsigned         row_pos = 0;
    int unsigned         held_px [4] = '{0, 0, 0, 0};
    logic [16:0]         pair_line [LINE_DEPTH][4];

    pixel_out_t          expected_averages [$];
    typed_outcome_t      typed_outcomes [$];

    bit                  quiet = 1'b0;
    bit                  gaps_on = 1'b1;
    int unsigned         mismatches = 0;
    int unsigned         pixels_sent = 0;
    int unsigned         averages_checked = 0;
    int unsigned         size_settings = 0;
    int unsigned         idle_cycles = 0;

    box_downsample_2x2 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_pixel (src_pixel),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_pixel (dst_pixel),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned clamp_size(logic [CFG_BITS-1:0] v, int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // Advance the predictor by one source pixel; return 1 with the block
    // average when this pixel completes a 2x2 block.
    function automatic bit predict_block_average(input pixel_in_t p, output pixel_out_t avg);
        int unsigned w;
        int unsigned h;
        int unsigned ow;
        int unsigned oh;
        int unsigned x;
        int unsigned chan [4];
        int unsigned pair [4];
        int unsigned sum [4];
        bit          have_pair;
        bit          made;

        chan[0] = p.red_in;
        chan[1] = p.green_in;
        chan[2] = p.blue_in;
        chan[3] = p.alpha_in;
        w = clamp_size(width_reg, MAX_WIDTH_DEF);
        h = clamp_size(height_reg, HEIGHT_LIMIT);
        ow = (w > 1) ? w / 2 : 1;
        oh = (h > 1) ? h / 2 : 1;
        x = col_pos >> 1;
        have_pair = 1'b0;
        made = 1'b0;
        avg = '0;
        sum = '{0, 0, 0, 0};

        // A single column is used twice; an odd last column is dropped.
        if (w == 1)
        begin
            for (int ch = 0; ch < 4; ch++)
                pair[ch] = 2 * chan[ch];
            have_pair = 1'b1;
            x = 0;
        end
        else if (col_pos < 2 * ow)
        begin
            if (col_pos % 2 == 0)
            begin
                held_px = chan;
            end
            else
            begin
                for (int ch = 0; ch < 4; ch++)
                    pair[ch] = held_px[ch] + chan[ch];
                have_pair = 1'b1;
            end
        end

        if (have_pair)
        begin
            if (h == 1)
            begin
                // A single row is used twice.
                for (int ch = 0; ch < 4; ch++)
                    sum[ch] = (pair[ch] * 2 + 2) >> 2;
                avg.frame_end = (x == ow - 1);
                made = 1'b1;
            end
            else if (row_pos < 2 * oh)
            begin
                if (row_pos % 2 == 0)
                begin
                    for (int ch = 0; ch < 4; ch++)
                        pair_line[x][ch] = 17'(pair[ch]);
                end
                else
                begin
                    for (int ch = 0; ch < 4; ch++)
                        sum[ch] = (pair_line[x][ch] + pair[ch] + 2) >> 2;
                    avg.frame_end = (x == ow - 1) && (row_pos == 2 * oh - 1);
                    made = 1'b1;
                end
            end
        end

        avg.red_out   = 16'(sum[0]);
        avg.green_out = 16'(sum[1]);
        avg.blue_out  = 16'(sum[2]);
        avg.alpha_out = 16'(sum[3]);

        // Wrap at the end of each row and at the end of the frame.
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
        return made;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    // Scoreboard, predictor and watchdog share one process so that the order
    // of output check, register write and input transfer within an edge is
    // fixed.
    always @(posedge clk)
    begin : scoreboard
        pixel_out_t     avg;
        pixel_out_t     oldest;
        typed_outcome_t typed;
        bit             made;
        bit             moved;

        if (rst_n)
        begin
            moved = 1'b0;
            if (dst_valid && dst_ready)
            begin
                moved = 1'b1;
                if (expected_averages.size() == 0)
                begin
                    $error("output pixel %h with no block average pending", dst_pixel);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_averages.pop_front();
                    check_field("red_out", oldest.red_out, dst_pixel.red_out);
                    check_field("green_out", oldest.green_out, dst_pixel.green_out);
                    check_field("blue_out", oldest.blue_out, dst_pixel.blue_out);
                    check_field("alpha_out", oldest.alpha_out, dst_pixel.alpha_out);
                    check_field("frame_end", oldest.frame_end, dst_pixel.frame_end);
                    averages_checked++;
                end
            end
            // Either register write restarts the frame.
            if (cfg_we)
            begin
                moved = 1'b1;
                if (cfg_index == REG_SOURCE_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                col_pos = 0;
                row_pos = 0;
            end
            if (src_valid && src_ready)
            begin
                moved = 1'b1;
                typed = typed_outcomes.pop_front();
                made = predict_block_average(src_pixel, avg);
                if (typed.pinned)
                    expected_averages.push_back(typed.want);
                else if (made)
                    expected_averages.push_back(avg);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no transfer for %0d cycles, %0d averages pending",
                         idle_cycles, expected_averages.size());
                $display("tb_box_downsample_2x2 failed");
                $finish;
            end
        end
    end

    // Output side: ready in random stretches, with random stalls between some of them.
    initial
    begin : sink
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            dst_ready <= 1'b1;
            repeat (quiet ? 1 : $urandom_range(1, 30)) @(posedge clk);
            if (!quiet && $urandom_range(0, 1) == 1)
            begin
                dst_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    end

    function automatic step_t write_row(logic idx, logic [CFG_BITS-1:0] v);
        step_t s;
        s = '{kind: ROW_WRITE, reg_index: idx, reg_value: v, px: '0, pinned: 1'b0, want: '0};
        return s;
    endfunction

    function automatic step_t pixel_row(pixel_in_t p);
        step_t s;
        s = '{kind: ROW_PIXEL, reg_index: REG_SOURCE_WIDTH, reg_value: '0, px: p,
              pinned: 1'b0, want: '0};
        return s;
    endfunction

    function automatic step_t pinned_row(pixel_in_t p, pixel_out_t o);
        step_t s;
        s = pixel_row(p);
        s.pinned = 1'b1;
        s.want = o;
        return s;
    endfunction

    // Random channel values, leaning on zero and full scale now and then.
    function automatic pixel_in_t rand_pixel();
        logic [15:0] c [4];
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(0, 7))
                0:       c[i] = 16'h0000;
                1:       c[i] = 16'hFFFF;
                default: c[i] = 16'($urandom());
            endcase
        end
        return {c[0], c[1], c[2], c[3]};
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_size();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_BITS'($urandom_range(4097, 8191));
            2:       return CFG_BITS'($urandom_range(13, 4096));
            default: return CFG_BITS'($urandom_range(1, 12));
        endcase
    endfunction

    // Present one pixel, possibly after a gap, and hold it until the transfer.
    task automatic send_pixel(pixel_in_t p, bit pinned, pixel_out_t want);
        typed_outcomes.push_back('{pinned: pinned, want: want});
        if (!quiet && gaps_on && $urandom_range(0, 3) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_pixel <= p;
        do
            @(posedge clk);
        while (!src_ready);
        pixels_sent++;
    endtask

    // Drop valid and wait until every block average is out and the pipeline
    // has emptied, so a register write meets an idle block.
    task automatic settle();
        src_valid <= 1'b0;
        while (expected_averages.size() != 0 || typed_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_BITS-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h, int unsigned n);
        settle();
        write_reg(REG_SOURCE_WIDTH, w);
        write_reg(REG_SOURCE_HEIGHT, h);
        gaps_on = ($urandom_range(0, 3) != 0);
        size_settings++;
        repeat (n) send_pixel(rand_pixel(), 1'b0, '0);
    endtask

    initial
    begin : stimulus
        step_t               directed_steps [$];
        logic [CFG_BITS-1:0] w_cfg;
        logic [CFG_BITS-1:0] h_cfg;
        int unsigned         w_eff;
        int unsigned         h_eff;
        int unsigned         frame_px;
        int unsigned         n;
        int unsigned         random_sent;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_steps = {
            // Out of reset the frame is 1x1: every pixel is its own average.
            pinned_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                       {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}),
            pinned_row({16'h0000, 16'h0000, 16'h0000, 16'h0000},
                       {16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}),
            pinned_row({16'h1234, 16'h0001, 16'h8000, 16'h7FFF},
                       {16'h1234, 16'h0001, 16'h8000, 16'h7FFF, 1'b1}),
            // 2x2 frame: full scale, then rounding at half steps.
            write_row(REG_SOURCE_WIDTH, 13'd2),
            write_row(REG_SOURCE_HEIGHT, 13'd2),
            pixel_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}),
            pixel_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}),
            pixel_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}),
            pinned_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                       {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}),
            pixel_row({16'h0000, 16'h0000, 16'h0001, 16'hFFFF}),
            pixel_row({16'h0000, 16'h0000, 16'h0001, 16'hFFFF}),
            pixel_row({16'h0000, 16'h0000, 16'h0000, 16'hFFFF}),
            pixel_row({16'h0001, 16'h0002, 16'h0000, 16'hFFFE}),
            // 3x3 frame: last column and last row are dropped.
            write_row(REG_SOURCE_WIDTH, 13'd3),
            write_row(REG_SOURCE_HEIGHT, 13'd3),
            pixel_row({16'h1111, 16'h2222, 16'h3333, 16'h4444}),
            pixel_row({16'h5555, 16'h6666, 16'h7777, 16'h8888}),
            pixel_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}),
            pixel_row({16'h9999, 16'hAAAA, 16'hBBBB, 16'hCCCC}),
            pixel_row({16'hDDDD, 16'hEEEE, 16'h0001, 16'h0003}),
            pixel_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}),
            pixel_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}),
            pixel_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}),
            pixel_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}),
            // Zero sizes act as 1.
            write_row(REG_SOURCE_WIDTH, 13'd0),
            write_row(REG_SOURCE_HEIGHT, 13'd0),
            pinned_row({16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0},
                       {16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0, 1'b1}),
            // Oversized width clamps to the maximum: first block is not the last.
            write_row(REG_SOURCE_WIDTH, 13'd8191),
            write_row(REG_SOURCE_HEIGHT, 13'd1),
            pixel_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}),
            pinned_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                       {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}),
            // Oversized height clamps likewise, with a single column.
            write_row(REG_SOURCE_WIDTH, 13'd1),
            write_row(REG_SOURCE_HEIGHT, 13'd8191),
            pixel_row({16'h8000, 16'h0001, 16'hFFFF, 16'h0000}),
            pixel_row({16'h7FFF, 16'h0002, 16'hFFFE, 16'h0001})
        };

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
            end
            else
            begin
                send_pixel(directed_steps[i].px, directed_steps[i].pinned,
                           directed_steps[i].want);
            end
        end

        // Slices of the size extremes: start of the widest row and of the
        // tallest single column.
        run_phase(13'd4096, 13'd1, 40);
        run_phase(13'd1, 13'd8191, 40);

        // Random sizes, mostly small: whole frames plus a partial tail that
        // the next write cuts off; large frames get only a slice.
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            w_cfg = pick_size();
            h_cfg = pick_size();
            w_eff = clamp_size(w_cfg, MAX_WIDTH_DEF);
            h_eff = clamp_size(h_cfg, HEIGHT_LIMIT);
            frame_px = w_eff * h_eff;
            if (frame_px <= 144)
                n = frame_px * $urandom_range(1, 2) + $urandom_range(0, w_eff);
            else
                n = $urandom_range(16, 160);
            if (n > RANDOM_PIXELS - random_sent)
                n = RANDOM_PIXELS - random_sent;
            run_phase(w_cfg, h_cfg, n);
            random_sent += n;
        end

        // Closing stretch at full rate on both sides.
        quiet = 1'b1;
        run_phase(13'd6, 13'd4, 48);

        src_valid <= 1'b0;
        while (expected_averages.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d source pixels over %0d size settings, checked %0d block averages",
                 pixels_sent, size_settings, averages_checked);
        $display("sizes ran from 1x1 up to slices of 4096-wide and 4096-tall frames, with odd, zero and oversize");
        if (mismatches == 0)
            $display("tb_box_downsample_2x2 passed");
        else
            $display("tb_box_downsample_2x2 failed");
        $finish;
    end

endmodule
